/* src/vrm_pkg.sv */
// Shared types, constants and address/region helpers for the video RAM mirror tracker.
package vrm_pkg;

    // Storage geometry: 96 KiB held as 32-bit words
    localparam int unsigned VRAM_WORDS = 24576;
    localparam int unsigned IDX_W      = 15;
    localparam int unsigned ADDR_W     = 17;
    localparam int unsigned DATA_W     = 32;

    // Screen region sizes in bytes
    localparam int unsigned MODE3_BYTES      = 76800;
    localparam int unsigned MODE4_PAGE_BYTES = 40960;
    localparam int unsigned MODE4_BYTES      = 38400;
    localparam int unsigned MODE5_BYTES      = 40960;
    localparam int unsigned MAP_REGION_BYTES = 65536;
    localparam int unsigned BG_TILE_BYTES    = 65536;

    // Visible span of one mode 4 page (a page never reaches past its stride)
    localparam int unsigned MODE4_SPAN =
        (MODE4_BYTES < MODE4_PAGE_BYTES) ? MODE4_BYTES : MODE4_PAGE_BYTES;
    localparam int unsigned MODE4_P1_LO  = MODE4_PAGE_BYTES;
    localparam int unsigned MODE4_P1_HI  = MODE4_PAGE_BYTES + MODE4_SPAN;
    localparam int unsigned MODE5_P1_LO  = MODE5_BYTES;
    localparam int unsigned MODE5_P1_HI  = 2 * MODE5_BYTES;

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_STORE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Access size codes (anything else acts as a word)
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // One request word after address mapping
    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        access_size;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    // Dirty flags, lsb is mode 3
    typedef struct packed {
        logic obj_chr;
        logic bg_chr;
        logic scroll_map;
        logic affine_map;
        logic mode5_page1;
        logic mode5_page0;
        logic mode4_page1;
        logic mode4_page0;
        logic mode3;
    } dirty_t;

    // Outcome of one read-modify-write step
    typedef struct packed {
        logic              wr_en;
        logic [DATA_W-1:0] wr_word;
        logic [DATA_W-1:0] read_data;
        dirty_t            set;
        logic              clear;
    } rmw_t;

    // Fold the 17-bit bus address onto the 96 KiB store
    function automatic logic [ADDR_W-1:0] map_address(input logic [ADDR_W-1:0] a);
        map_address = a[16] ? {2'b10, a[14:0]} : {1'b0, a[15:0]};
    endfunction

    // Regions that hold a mapped byte address
    function automatic dirty_t region_of(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        dirty_t      d;
        w             = {{(32 - ADDR_W){1'b0}}, a};
        d.mode3       = (w < MODE3_BYTES);
        d.mode4_page0 = (w < MODE4_SPAN);
        d.mode4_page1 = (w >= MODE4_P1_LO) && (w < MODE4_P1_HI);
        d.mode5_page0 = (w < MODE5_BYTES);
        d.mode5_page1 = (w >= MODE5_P1_LO) && (w < MODE5_P1_HI);
        d.affine_map  = (w < MAP_REGION_BYTES);
        d.scroll_map  = (w < MAP_REGION_BYTES);
        d.bg_chr      = (w < BG_TILE_BYTES);
        d.obj_chr     = !(w < BG_TILE_BYTES);
        region_of     = d;
    endfunction

endpackage

/* src/vrm_if.sv */
// Request and response channel interfaces.
interface vrm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  access_size;
    logic [16:0] address;
    logic [31:0] write_data;

    modport source (output valid, output req_type, output access_size,
                    output address, output write_data, input ready);
    modport sink   (input valid, input req_type, input access_size,
                    input address, input write_data, output ready);
    modport mon    (input valid, input ready, input req_type, input access_size,
                    input address, input write_data);
endinterface

interface vrm_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        dirty_mode3;
    logic        dirty_mode4_page0;
    logic        dirty_mode4_page1;
    logic        dirty_mode5_page0;
    logic        dirty_mode5_page1;
    logic        dirty_affine_map;
    logic        dirty_scroll_map;
    logic        dirty_bg_chr;
    logic        dirty_obj_chr;

    modport source (output valid, output read_data, output dirty_mode3,
                    output dirty_mode4_page0, output dirty_mode4_page1,
                    output dirty_mode5_page0, output dirty_mode5_page1,
                    output dirty_affine_map, output dirty_scroll_map,
                    output dirty_bg_chr, output dirty_obj_chr, input ready);
    modport sink   (input valid, input read_data, input dirty_mode3,
                    input dirty_mode4_page0, input dirty_mode4_page1,
                    input dirty_mode5_page0, input dirty_mode5_page1,
                    input dirty_affine_map, input dirty_scroll_map,
                    input dirty_bg_chr, input dirty_obj_chr, output ready);
    modport mon    (input valid, input ready, input read_data, input dirty_mode3,
                    input dirty_mode4_page0, input dirty_mode4_page1,
                    input dirty_mode5_page0, input dirty_mode5_page1,
                    input dirty_affine_map, input dirty_scroll_map,
                    input dirty_bg_chr, input dirty_obj_chr);
endinterface

/* src/vrm_ram.sv */
// Two-port video word store: one registered read and one write per cycle.
module vrm_ram (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [vrm_pkg::IDX_W-1:0]    rd_idx,
    output logic [vrm_pkg::DATA_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [vrm_pkg::IDX_W-1:0]    wr_idx,
    input  logic [vrm_pkg::DATA_W-1:0]   wr_data
);

    logic [vrm_pkg::DATA_W-1:0] mem [0:vrm_pkg::VRAM_WORDS-1];
    logic [vrm_pkg::DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/vrm_rmw.sv */
// Load extraction, store merge/compare and dirty-region marking for one word.
module vrm_rmw (
    input  vrm_pkg::req_t                req,
    input  logic [vrm_pkg::DATA_W-1:0]   old_word,
    output vrm_pkg::rmw_t                res
);

    logic [15:0] old_half;
    logic [15:0] v16;
    logic [31:0] merged;
    logic [16:0] half_addr;
    logic [16:0] word_addr;

    // Halfword view of the stored word
    assign old_half  = req.address[1] ? old_word[31:16] : old_word[15:0];
    assign v16       = (req.access_size == vrm_pkg::SIZE_BYTE)
                       ? {req.write_data[7:0], req.write_data[7:0]}
                       : req.write_data[15:0];
    assign merged    = req.address[1] ? {v16, old_word[15:0]} : {old_word[31:16], v16};
    assign half_addr = {req.address[16:1], 1'b0};
    assign word_addr = {req.address[16:2], 2'b00};

    always_comb
    begin
        res.wr_en     = 1'b0;
        res.wr_word   = merged;
        res.read_data = '0;
        res.set       = '0;
        res.clear     = 1'b0;
        case (req.req_type)
            vrm_pkg::REQ_LOAD:
            begin
                case (req.access_size)
                    vrm_pkg::SIZE_BYTE:
                    begin
                        case (req.address[1:0])
                            2'd0:    res.read_data = {24'd0, old_word[7:0]};
                            2'd1:    res.read_data = {24'd0, old_word[15:8]};
                            2'd2:    res.read_data = {24'd0, old_word[23:16]};
                            default: res.read_data = {24'd0, old_word[31:24]};
                        endcase
                    end
                    vrm_pkg::SIZE_HALF: res.read_data = {16'd0, old_half};
                    default:            res.read_data = old_word;
                endcase
            end
            vrm_pkg::REQ_STORE:
            begin
                case (req.access_size)
                    vrm_pkg::SIZE_BYTE:
                    begin
                        // byte stores to the upper 32 KiB are dropped
                        if (!req.address[16] && (old_half != v16))
                        begin
                            res.wr_en = 1'b1;
                            res.set   = vrm_pkg::region_of(half_addr);
                        end
                    end
                    vrm_pkg::SIZE_HALF:
                    begin
                        if (old_half != v16)
                        begin
                            res.wr_en = 1'b1;
                            res.set   = vrm_pkg::region_of(half_addr);
                        end
                    end
                    default:
                    begin
                        res.wr_word = req.write_data;
                        // equal word: nothing to write
                        if (old_word == req.write_data)
                        begin
                            res.wr_en = 1'b0;
                        end
                        else
                        begin
                            res.wr_en = 1'b1;
                            res.set   = vrm_pkg::region_of(word_addr);
                        end
                    end
                endcase
            end
            vrm_pkg::REQ_CLEAR: res.clear = 1'b1;
            default:            res.clear = 1'b0;
        endcase
    end

endmodule

/* src/video_ram_mirror_dirty_tracker.sv */
// Top level: video RAM with address mirroring and dirty-region tracking.
//
//  channel    dir   handshake      payload
//  request    in    valid/ready    req_type, access_size, address, write_data
//  response   out   valid/ready    read_data, nine dirty flags
//
//  The RAM read issues in the accept cycle; merge, compare, write-back and
//  flag update run when the working stage advances. Words stream at one per
//  cycle unless the response stalls; a write to the word just read is forwarded.
//  Reset clears the dirty flags and the valid bits; RAM contents are undefined
//  until written, so there is no clearing pass.
//  A stalled response holds the working stage, and the request side stalls behind it.
module video_ram_mirror_dirty_tracker (
    input  logic       clk,
    input  logic       rst_n,
    vrm_req_if.sink    request,
    vrm_rsp_if.source  response
);

    vrm_pkg::req_t              in_req;
    vrm_pkg::req_t              s1_req_reg;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       fwd_hit_reg;
    logic [vrm_pkg::DATA_W-1:0] fwd_data_reg;
    logic [vrm_pkg::DATA_W-1:0] ram_rdata;
    logic [vrm_pkg::DATA_W-1:0] old_word;
    vrm_pkg::rmw_t              rmw;
    vrm_pkg::dirty_t            flags_reg;
    vrm_pkg::dirty_t            flags_next;
    logic                       out_valid_reg;
    logic [vrm_pkg::DATA_W-1:0] out_data_reg;
    vrm_pkg::dirty_t            out_flags_reg;
    logic                       advance;
    logic                       accept;
    logic                       wr_en;
    logic [vrm_pkg::IDX_W-1:0]  in_idx;
    logic [vrm_pkg::IDX_W-1:0]  s1_idx;

    // Incoming word with the mirror folded in
    always_comb
    begin
        in_req.req_type    = request.req_type;
        in_req.access_size = request.access_size;
        in_req.address     = vrm_pkg::map_address(request.address);
        in_req.write_data  = request.write_data;
    end

    assign in_idx = in_req.address[16:2];
    assign s1_idx = s1_req_reg.address[16:2];

    // Handshake
    assign advance       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || advance;
    assign accept        = request.valid && request.ready;
    assign wr_en         = advance && rmw.wr_en;

    vrm_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_idx  (in_idx),
        .rd_data (ram_rdata),
        .wr_en   (wr_en),
        .wr_idx  (s1_idx),
        .wr_data (rmw.wr_word)
    );

    // Stored word, patched when the previous word wrote it during the read
    assign old_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    vrm_rmw u_rmw (
        .req      (s1_req_reg),
        .old_word (old_word),
        .res      (rmw)
    );

    assign flags_next    = rmw.clear ? '0 : (flags_reg | rmw.set);
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working stage and forward capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= in_req;
            fwd_hit_reg  <= wr_en && (s1_idx == in_idx);
            fwd_data_reg <= rmw.wr_word;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg  <= rmw.read_data;
            out_flags_reg <= flags_next;
        end
    end

    assign response.valid             = out_valid_reg;
    assign response.read_data         = out_data_reg;
    assign response.dirty_mode3       = out_flags_reg.mode3;
    assign response.dirty_mode4_page0 = out_flags_reg.mode4_page0;
    assign response.dirty_mode4_page1 = out_flags_reg.mode4_page1;
    assign response.dirty_mode5_page0 = out_flags_reg.mode5_page0;
    assign response.dirty_mode5_page1 = out_flags_reg.mode5_page1;
    assign response.dirty_affine_map  = out_flags_reg.affine_map;
    assign response.dirty_scroll_map  = out_flags_reg.scroll_map;
    assign response.dirty_bg_chr      = out_flags_reg.bg_chr;
    assign response.dirty_obj_chr     = out_flags_reg.obj_chr;

endmodule

/* src/vrm_checker.sv */
// Port-level checks for the video RAM tracker, bound to the top level.
module vrm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [31:0] read_data,
    input  logic        dirty_mode3,
    input  logic        dirty_mode4_page0,
    input  logic        dirty_mode5_page0,
    input  logic        dirty_affine_map,
    input  logic        dirty_scroll_map,
    input  logic        dirty_bg_chr,
    input  logic        dirty_obj_chr
);

    // A held response keeps its word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(read_data)
            && $stable(dirty_mode3) && $stable(dirty_obj_chr))
        else $error("response changed while stalled");

    // Nothing is in flight right after reset
    a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

    // Both tilemap flags cover the same range
    a_maps_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (dirty_affine_map == dirty_scroll_map))
        else $error("tilemap flags disagree");

    // Mode 4 first page lies inside mode 3, mode 5 first page, the map area and the bg tiles
    a_page0_nested: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && dirty_mode4_page0 |->
            dirty_mode3 && dirty_mode5_page0
            && dirty_affine_map && dirty_bg_chr)
        else $error("mode 4 page 0 flag without its enclosing regions");

endmodule

bind video_ram_mirror_dirty_tracker vrm_checker u_vrm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (response.valid),
    .rsp_ready         (response.ready),
    .read_data         (response.read_data),
    .dirty_mode3       (response.dirty_mode3),
    .dirty_mode4_page0 (response.dirty_mode4_page0),
    .dirty_mode5_page0 (response.dirty_mode5_page0),
    .dirty_affine_map  (response.dirty_affine_map),
    .dirty_scroll_map  (response.dirty_scroll_map),
    .dirty_bg_chr      (response.dirty_bg_chr),
    .dirty_obj_chr     (response.dirty_obj_chr)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the video RAM mirror and dirty tracker.
module testbench;

    localparam logic [1:0] REQ_NONE  = 2'd3;   // request code the block ignores
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_ODD  = 2'd3;   // undefined size, behaves as a word

    localparam int unsigned BYTE_STORE_LIMIT = 64 * 1024;
    localparam int unsigned MIRROR_BASE      = 'h10000;
    localparam int unsigned MIRROR_SPAN      = 'h8000;
    localparam int unsigned PHASE_WORDS      = 295;
    localparam int unsigned SPARE_WORDS      = 80;
    localparam int unsigned HOLD_AT          = 600;
    localparam int unsigned HOLD_CYCLES      = 120;
    localparam int unsigned PRINT_CAP        = 200;
    localparam int          DIRECTED_ROWS    = 25;

    typedef struct {
        logic [31:0]     read_data;
        vrm_pkg::dirty_t flags;
        bit              flags_care;
    } vram_rsp_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [1:0]      access_size;
        logic [16:0]     address;
        logic [31:0]     write_data;
        logic            typed;
        logic [31:0]     read_data;
        vrm_pkg::dirty_t flags;
    } table_row_t;

    logic clk;
    logic rst_n;

    vrm_req_if req_ch ();
    vrm_rsp_if rsp_ch ();

    video_ram_mirror_dirty_tracker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // Predicted memory image and flags
    logic [31:0]     vram_image [int unsigned];
    vrm_pkg::dirty_t region_flags;
    bit              flags_known;

    int unsigned word_pool [$];     // word indexes the traffic may touch
    vram_rsp_t   rsp_due_q [$];     // responses still owed by the block
    int unsigned fail_count;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    string flag_name [9] = '{"dirty_mode3", "dirty_mode4_page0", "dirty_mode4_page1",
                             "dirty_mode5_page0", "dirty_mode5_page1", "dirty_affine_map",
                             "dirty_scroll_map", "dirty_bg_chr", "dirty_obj_chr"};

    // Directed table; flag values are {obj, bg, scroll, affine, m5p1, m5p0, m4p1, m4p0, m3}
    table_row_t directed_rows [DIRECTED_ROWS] = '{
        '{vrm_pkg::REQ_CLEAR, SIZE_WORD, 17'h00000, 32'h00000000,
          1'b1, 32'h00000000, 9'h000},
        '{REQ_NONE, SIZE_ODD, 17'h1FFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, 9'h000},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h00000, 32'hFFFFFFFF,
          1'b1, 32'h00000000, 9'h0EB},
        '{vrm_pkg::REQ_LOAD, SIZE_WORD, 17'h00003, 32'h00000000,
          1'b1, 32'hFFFFFFFF, 9'h0EB},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h00000, 32'hFFFFFFFF, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_CLEAR, vrm_pkg::SIZE_BYTE, 17'h00000, 32'h00000000,
          1'b1, 32'h00000000, 9'h000},
        '{vrm_pkg::REQ_STORE, vrm_pkg::SIZE_BYTE, 17'h00001, 32'h000000A5,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_LOAD, vrm_pkg::SIZE_BYTE, 17'h00000, 32'h00000000,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_LOAD, vrm_pkg::SIZE_HALF, 17'h00003, 32'h00000000,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, vrm_pkg::SIZE_HALF, 17'h1FFFF, 32'hFFFF1234,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_LOAD, vrm_pkg::SIZE_HALF, 17'h17FFE, 32'h00000000,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, vrm_pkg::SIZE_BYTE, 17'h10000, 32'h0000003C,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_LOAD, vrm_pkg::SIZE_BYTE, 17'h18001, 32'h00000000,
          1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h095FC, 32'h12345678, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h09600, 32'h9ABCDEF0, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h0A000, 32'h0F0F0F0F, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h12BFC, 32'h55555555, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h12C00, 32'hAAAAAAAA, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h135FC, 32'h01234567, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h1B600, 32'h89ABCDEF, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h13FFC, 32'h00000001, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_WORD, 17'h1C000, 32'h80000000, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_STORE, SIZE_ODD, 17'h0FFFF, 32'hDEADBEEF, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_LOAD, SIZE_ODD, 17'h0FFFE, 32'h00000000, 1'b0, 32'h0, 9'h0},
        '{vrm_pkg::REQ_CLEAR, vrm_pkg::SIZE_HALF, 17'h00000, 32'h00000000,
          1'b1, 32'h00000000, 9'h000}
    };

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Upper 64 KiB half of the bus folds onto 0x10000-0x17FFF
    function automatic int unsigned fold_address(input logic [16:0] addr);
        int unsigned a;
        a = {15'd0, addr};
        if (a >= MIRROR_BASE)
            a = MIRROR_BASE + (a % MIRROR_SPAN);
        return a;
    endfunction

    // Pick either bus alias of a mapped byte address
    function automatic logic [16:0] bus_alias(input int unsigned m);
        if (m >= MIRROR_BASE && $urandom_range(0, 1) == 1)
            return 17'(m + MIRROR_SPAN);
        return 17'(m);
    endfunction

    // Set the flags of every screen region that holds byte a
    function automatic void mark_regions(input int unsigned a);
        int unsigned p4;
        int unsigned p5;
        p4 = a / vrm_pkg::MODE4_PAGE_BYTES;
        p5 = a / vrm_pkg::MODE5_BYTES;
        if (a < vrm_pkg::MODE3_BYTES)
            region_flags.mode3 = 1'b1;
        if (p4 < 2 && (a % vrm_pkg::MODE4_PAGE_BYTES) < vrm_pkg::MODE4_BYTES)
        begin
            if (p4 == 0)
                region_flags.mode4_page0 = 1'b1;
            else
                region_flags.mode4_page1 = 1'b1;
        end
        if (p5 == 0)
            region_flags.mode5_page0 = 1'b1;
        else if (p5 == 1)
            region_flags.mode5_page1 = 1'b1;
        if (a < vrm_pkg::MAP_REGION_BYTES)
        begin
            region_flags.affine_map = 1'b1;
            region_flags.scroll_map = 1'b1;
        end
        if (a < vrm_pkg::BG_TILE_BYTES)
            region_flags.bg_chr = 1'b1;
        else
            region_flags.obj_chr = 1'b1;
    endfunction

    // Halfword write, only when the value changes
    function automatic void write_half(input int unsigned a, input logic [15:0] v16);
        logic [31:0] held;
        held = vram_image[a >> 2];
        if ((a & 2) != 0)
        begin
            if (held[31:16] != v16)
            begin
                vram_image[a >> 2] = {v16, held[15:0]};
                mark_regions(a);
            end
        end
        else if (held[15:0] != v16)
        begin
            vram_image[a >> 2] = {held[31:16], v16};
            mark_regions(a);
        end
    endfunction

    // Word write; the very first write of a word leaves the flags unpredictable
    function automatic void write_word(input int unsigned a, input logic [31:0] v32);
        if (!vram_image.exists(a >> 2))
        begin
            vram_image[a >> 2] = v32;
            flags_known = 1'b0;
        end
        else if (vram_image[a >> 2] != v32)
        begin
            vram_image[a >> 2] = v32;
            mark_regions(a);
        end
    endfunction

    // Advance the predicted state by one accepted request and return its response
    function automatic vram_rsp_t compute_vram_response(input vrm_pkg::req_t acc);
        vram_rsp_t   rsp;
        int unsigned a;
        logic [31:0] held;
        logic [7:0]  b;
        a = fold_address(acc.address);
        rsp.read_data = '0;
        case (acc.req_type)
            vrm_pkg::REQ_LOAD:
            begin
                held = vram_image[a >> 2];
                case (acc.access_size)
                    vrm_pkg::SIZE_BYTE:
                        rsp.read_data = (held >> (8 * (a % 4))) & 32'hFF;
                    vrm_pkg::SIZE_HALF:
                        rsp.read_data = ((a & 2) != 0) ? {16'd0, held[31:16]}
                                                       : {16'd0, held[15:0]};
                    default:
                        rsp.read_data = held;
                endcase
            end
            vrm_pkg::REQ_STORE:
            begin
                case (acc.access_size)
                    vrm_pkg::SIZE_BYTE:
                    begin
                        // byte lands in both halves; dropped in the object area
                        b = acc.write_data[7:0];
                        if ((a & ~32'd1) < BYTE_STORE_LIMIT)
                            write_half(a & ~32'd1, {b, b});
                    end
                    vrm_pkg::SIZE_HALF: write_half(a & ~32'd1, acc.write_data[15:0]);
                    default:            write_word(a & ~32'd3, acc.write_data);
                endcase
            end
            vrm_pkg::REQ_CLEAR:
            begin
                region_flags = '0;
                flags_known  = 1'b1;
            end
            default: ;
        endcase
        rsp.flags      = region_flags;
        rsp.flags_care = flags_known;
        return rsp;
    endfunction

    // Region edges plus a random spread of words
    function automatic void build_word_pool();
        int unsigned edges [14] = '{'h00000, 'h095FC, 'h09600, 'h09FFC, 'h0A000, 'h0FFFC,
                                    'h10000, 'h12BFC, 'h12C00, 'h135FC, 'h13600, 'h13FFC,
                                    'h14000, 'h17FFC};
        bit          taken [int unsigned];
        int unsigned w;
        foreach (edges[i])
        begin
            word_pool.push_back(edges[i] / 4);
            taken[edges[i] / 4] = 1'b1;
        end
        while (word_pool.size() < 14 + SPARE_WORDS)
        begin
            w = $urandom_range(0, vrm_pkg::VRAM_WORDS - 1);
            if (!taken.exists(w))
            begin
                taken[w] = 1'b1;
                word_pool.push_back(w);
            end
        end
    endfunction

    // Random request on a word that is already filled
    function automatic vrm_pkg::req_t random_access();
        vrm_pkg::req_t acc;
        int unsigned   w;
        int unsigned   m;
        int unsigned   pick;
        logic [31:0]   held;
        w    = word_pool[$urandom_range(0, word_pool.size() - 1)];
        m    = w * 4 + $urandom_range(0, 3);
        held = vram_image[w];
        pick = $urandom_range(0, 99);
        if (pick < 40)
            acc.req_type = vrm_pkg::REQ_LOAD;
        else if (pick < 85)
            acc.req_type = vrm_pkg::REQ_STORE;
        else if (pick < 95)
            acc.req_type = vrm_pkg::REQ_CLEAR;
        else
            acc.req_type = REQ_NONE;
        case ($urandom_range(0, 7))
            0, 1, 2: acc.access_size = vrm_pkg::SIZE_BYTE;
            3, 4:    acc.access_size = vrm_pkg::SIZE_HALF;
            5, 6:    acc.access_size = SIZE_WORD;
            default: acc.access_size = SIZE_ODD;
        endcase
        acc.address    = bus_alias(m);
        acc.write_data = $urandom();
        if ($urandom_range(0, 3) == 0)
        begin
            // rewrite what is held so the unchanged path gets traffic
            case (acc.access_size)
                vrm_pkg::SIZE_BYTE:
                    acc.write_data[7:0]  = ((m & 2) != 0) ? held[23:16] : held[7:0];
                vrm_pkg::SIZE_HALF:
                    acc.write_data[15:0] = ((m & 2) != 0) ? held[31:16] : held[15:0];
                default:
                    acc.write_data = held;
            endcase
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        // keep the log bounded on a badly broken block
        if (fail_count <= PRINT_CAP)
            $display("mismatch %0d at %0t: %s", fail_count, $time, msg);
    endtask

    // Offer one request word, with random gaps, and log its response once accepted
    task automatic send_access(input vrm_pkg::req_t acc, input bit typed,
                               input vram_rsp_t typed_rsp);
        vram_rsp_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= acc.req_type;
        req_ch.access_size <= acc.access_size;
        req_ch.address     <= acc.address;
        req_ch.write_data  <= acc.write_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = compute_vram_response(acc);
        if (typed)
            rsp_due_q.push_back(typed_rsp);
        else
            rsp_due_q.push_back(predicted);
    endtask

    task automatic wait_drained();
        while (rsp_due_q.size() != 0)
            @(posedge clk);
    endtask

    // Compare one accepted response word with the oldest one owed
    task automatic check_response();
        vram_rsp_t       due;
        vrm_pkg::dirty_t got;
        got = {rsp_ch.dirty_obj_chr, rsp_ch.dirty_bg_chr, rsp_ch.dirty_scroll_map,
               rsp_ch.dirty_affine_map, rsp_ch.dirty_mode5_page1, rsp_ch.dirty_mode5_page0,
               rsp_ch.dirty_mode4_page1, rsp_ch.dirty_mode4_page0, rsp_ch.dirty_mode3};
        if (rsp_due_q.size() == 0)
        begin
            report_mismatch($sformatf("response word with none outstanding, read_data %h",
                                      rsp_ch.read_data));
            return;
        end
        due = rsp_due_q.pop_front();
        if (rsp_ch.read_data !== due.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      rsp_ch.read_data, due.read_data));
        if (due.flags_care)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (got[k] !== due.flags[k])
                    report_mismatch($sformatf("%s got %b want %b",
                                              flag_name[k], got[k], due.flags[k]));
            end
        end
    endtask

    // Response side: check, then choose ready for the next cycle
    initial
    begin
        int unsigned rsp_count;
        int unsigned hold_left;
        rsp_count = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                check_response();
                rsp_count++;
                // one long hold-off so the request side backs up
                if (rsp_count == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        vrm_pkg::req_t acc;
        vram_rsp_t     no_rsp;
        vram_rsp_t     row_rsp;
        int unsigned   counted;
        fail_count   = 0;
        region_flags = '0;
        flags_known  = 1'b1;
        src_idle_pct = 38;
        snk_idle_pct = 45;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= vrm_pkg::REQ_LOAD;
        req_ch.access_size <= vrm_pkg::SIZE_BYTE;
        req_ch.address     <= '0;
        req_ch.write_data  <= '0;
        build_word_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every word the traffic touches; flags are unchecked until the first clear
        foreach (word_pool[i])
        begin
            acc.req_type    = vrm_pkg::REQ_STORE;
            acc.access_size = SIZE_WORD;
            acc.address     = bus_alias(word_pool[i] * 4);
            acc.write_data  = (word_pool[i] == 0) ? 32'h0 : $urandom();
            send_access(acc, 1'b0, no_rsp);
        end

        // Directed table
        foreach (directed_rows[i])
        begin
            acc.req_type        = directed_rows[i].req_type;
            acc.access_size     = directed_rows[i].access_size;
            acc.address         = directed_rows[i].address;
            acc.write_data      = directed_rows[i].write_data;
            row_rsp.read_data   = directed_rows[i].read_data;
            row_rsp.flags       = directed_rows[i].flags;
            row_rsp.flags_care  = 1'b1;
            send_access(acc, directed_rows[i].typed, row_rsp);
        end

        // Random traffic under three idle mixes, draining between them
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 45 : 0;
            snk_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 38 : 0;
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                acc = random_access();
                send_access(acc, 1'b0, no_rsp);
                if (acc.req_type != REQ_NONE)
                    counted++;
            end
            req_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[video_ram_mirror_dirty_tracker] OK");
        else
            $display("[video_ram_mirror_dirty_tracker] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[video_ram_mirror_dirty_tracker] ERROR");
        $finish;
    end

endmodule
